>>> hdl/nstd_pkg.sv
// shared types and constants for the note sequence tempo detector
// no dependencies; imported by every module of the block
`default_nettype none

package nstd_pkg;

    localparam int NOTE_W        = 7;
    localparam int IN_TIME_W     = 48;
    localparam int PATTERN_SLOTS = 8;
    localparam int PATTERN_W     = NOTE_W * PATTERN_SLOTS;
    localparam int LEN_W         = 4;
    localparam int DB_POS_W      = 3;
    localparam int BEATS_W       = 16;
    localparam int TEMPO_W       = 24;
    localparam int SEQ_W         = 32;
    localparam int CFG_DATA_W    = PATTERN_W;
    localparam int CFG_INDEX_W   = 2;

    localparam int DEF_MAX_NOTES = 8;
    localparam int DEF_TIME_BITS = 48;

    // product of beats and microseconds per minute
    localparam int USEC_W = 26;
    localparam int NUM_W  = BEATS_W + USEC_W;
    localparam logic [USEC_W-1:0]  USEC_PER_MINUTE = USEC_W'(60000000);
    localparam logic [TEMPO_W-1:0] TEMPO_MAX       = {TEMPO_W{1'b1}};

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_NOTES     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DOWNBEAT_POSITION = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_BEATS_Q8    = 2'd3;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern_notes;
        logic [LEN_W-1:0]     pattern_length;
        logic [DB_POS_W-1:0]  downbeat_position;
        logic [BEATS_W-1:0]   total_beats_q8;
    } nstd_cfg_t;

    // one detection waiting for its tempo division
    typedef struct packed {
        logic [BEATS_W-1:0]   total_beats_q8;
        logic [IN_TIME_W-1:0] elapsed;
        logic [IN_TIME_W-1:0] downbeat_time;
        logic [SEQ_W-1:0]     sequence_number;
    } nstd_job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_OUT
    } nstd_back_state_t;

endpackage

`default_nettype wire

>>> hdl/nstd_if.sv
// request channel interfaces: note events in, tempo detections out
// depends on nstd_pkg for field widths
`default_nettype none

interface nstd_note_if
    import nstd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [NOTE_W-1:0]    note_number;
    logic [NOTE_W-1:0]    note_velocity;
    logic [IN_TIME_W-1:0] event_time_us;

    modport source (output valid, output note_number, output note_velocity,
                    output event_time_us, input ready);
    modport sink   (input valid, input note_number, input note_velocity,
                    input event_time_us, output ready);
endinterface

interface nstd_tempo_if
    import nstd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [TEMPO_W-1:0]   tempo_q8;
    logic [IN_TIME_W-1:0] downbeat_time_us;
    logic [SEQ_W-1:0]     sequence_number;
    logic                 zero_elapsed;

    modport source (output valid, output tempo_q8, output downbeat_time_us,
                    output sequence_number, output zero_elapsed, input ready);
    modport sink   (input valid, input tempo_q8, input downbeat_time_us,
                    input sequence_number, input zero_elapsed, output ready);
endinterface

`default_nettype wire

>>> hdl/note_sequence_tempo_detector_core.sv
// note sequence tempo detector: a note is accepted whenever the two-entry
// detection queue has room; non-detecting notes produce nothing
// a detection passes the queue, a multiply, 42 divide steps (skipped for a
// zero elapsed time) and a result register; a new detection starts only once
// the last result is taken, with up to two more detections held in the queue
// reset clears match state and detection count, configuration to defaults
`default_nettype none

module note_sequence_tempo_detector_core
    import nstd_pkg::*;
#(
    parameter int MAX_NOTES = DEF_MAX_NOTES,
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    nstd_note_if.sink                   note,
    nstd_tempo_if.source                tempo,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    nstd_cfg_t cfg_reg, cfg_next;
    nstd_job_t push_job;
    nstd_job_t pop_job;
    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_NOTES:     cfg_next.pattern_notes     = cfg_data[PATTERN_W-1:0];
                REG_PATTERN_LENGTH:    cfg_next.pattern_length    = cfg_data[LEN_W-1:0];
                REG_DOWNBEAT_POSITION: cfg_next.downbeat_position = cfg_data[DB_POS_W-1:0];
                REG_TOTAL_BEATS_Q8:    cfg_next.total_beats_q8    = cfg_data[BEATS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_notes     <= '0;
            cfg_reg.pattern_length    <= LEN_W'(1);
            cfg_reg.downbeat_position <= '0;
            cfg_reg.total_beats_q8    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    nstd_front #(
        .MAX_NOTES (MAX_NOTES),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .note       (note),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    nstd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    nstd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .job         (pop_job),
        .pop         (pop),
        .tempo       (tempo)
    );

endmodule

`default_nettype wire

>>> hdl/nstd_front.sv
// front end: accepts note requests, tracks the pattern match position
// and pushes one job per detection; depends on nstd_pkg and nstd_if
`default_nettype none

module nstd_front
    import nstd_pkg::*;
#(
    parameter int MAX_NOTES = DEF_MAX_NOTES,
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    nstd_note_if.sink        note,
    input  wire nstd_cfg_t   cfg,
    input  wire logic        queue_full,
    output logic             push,
    output nstd_job_t        push_job
);

    localparam int POS_W  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int TW     = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
    localparam bit WIDE_TIME = (TIME_BITS > IN_TIME_W);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [TW-1:0]     first_time_reg, first_time_next;
    logic [TW-1:0]     db_time_reg, db_time_next;
    logic [SEQ_W-1:0]  count_reg, count_next;

    logic [NOTE_W-1:0] entries [PATTERN_SLOTS];
    logic [NOTE_W-1:0] expected;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  pos_ext;
    logic [TW-1:0]     now;
    logic [TW-1:0]     first_eff;
    logic [TW-1:0]     db_eff;
    logic [TW-1:0]     elapsed;
    logic              accept;
    logic              at_first;
    logic              at_downbeat;
    logic              last_note;

    // any accepted note may complete the pattern, so hold off while full
    assign note.ready = !queue_full;
    assign accept     = note.valid && note.ready;

    always_comb
    begin
        for (int i = 0; i < PATTERN_SLOTS; i++)
        begin
            entries[i] = cfg.pattern_notes[i*NOTE_W +: NOTE_W];
        end
    end

    always_comb
    begin
        if (cfg.pattern_length == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (cfg.pattern_length > LEN_W'(MAX_NOTES))
        begin
            eff_len = LEN_W'(MAX_NOTES);
        end
        else
        begin
            eff_len = cfg.pattern_length;
        end
    end

    assign pos_ext     = LEN_W'(pos_reg);
    assign expected    = entries[DB_POS_W'(pos_reg)];
    assign now         = note.event_time_us[TW-1:0];
    assign at_first    = (pos_reg == '0);
    assign at_downbeat = (pos_ext == LEN_W'(cfg.downbeat_position));
    assign last_note   = ((pos_ext + LEN_W'(1)) >= eff_len);
    assign first_eff   = at_first ? now : first_time_reg;
    assign db_eff      = at_downbeat ? now : db_time_reg;
    assign elapsed     = now - first_eff;

    always_comb
    begin
        pos_next        = pos_reg;
        first_time_next = first_time_reg;
        db_time_next    = db_time_reg;
        count_next      = count_reg;
        push            = 1'b0;
        if (accept && (note.note_velocity != '0))
        begin
            if (note.note_number != expected)
            begin
                pos_next = '0;
            end
            else
            begin
                first_time_next = first_eff;
                db_time_next    = db_eff;
                if (last_note)
                begin
                    pos_next   = '0;
                    push       = 1'b1;
                    count_next = count_reg + SEQ_W'(1);
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    // with a time width beyond the stamp, a backwards step wraps to a span
    // far above any numerator, so the largest divisor gives the same tempo
    always_comb
    begin
        push_job.total_beats_q8  = cfg.total_beats_q8;
        push_job.elapsed         = (WIDE_TIME && (now < first_eff)) ? '1
                                                                     : IN_TIME_W'(elapsed);
        push_job.downbeat_time   = IN_TIME_W'(db_eff);
        push_job.sequence_number = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            first_time_reg <= '0;
            db_time_reg    <= '0;
            count_reg      <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            first_time_reg <= first_time_next;
            db_time_reg    <= db_time_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/nstd_queue.sv
// short job queue between the match front end and the divider back end
// depends on nstd_pkg
`default_nettype none

module nstd_queue
    import nstd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire nstd_job_t  push_job,
    input  wire logic       pop,
    output nstd_job_t       pop_job,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    nstd_job_t         slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/nstd_back.sv
// back end: scales beats to microseconds per minute, runs a one bit per
// cycle restoring divide and holds the result; depends on nstd_pkg, nstd_if
`default_nettype none

module nstd_back
    import nstd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       queue_empty,
    input  wire nstd_job_t  job,
    output logic            pop,
    nstd_tempo_if.source    tempo
);

    localparam int STEP_W = $clog2(NUM_W);

    nstd_back_state_t      state_reg, state_next;
    logic [STEP_W-1:0]     step_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [NUM_W-1:0]      quo_reg;
    logic [IN_TIME_W-1:0]  rem_reg;
    logic [IN_TIME_W-1:0]  div_reg;
    logic [BEATS_W-1:0]    beats_reg;
    logic [IN_TIME_W-1:0]  db_time_reg;
    logic [SEQ_W-1:0]      seq_reg;
    logic                  zero_reg;
    logic [TEMPO_W-1:0]    tempo_reg;

    logic [IN_TIME_W:0]    trial;
    logic                  fits;
    logic [IN_TIME_W-1:0]  rem_step;
    logic [NUM_W-1:0]      quo_step;
    logic                  last_step;

    // restoring step: bring down the next numerator bit, subtract if it fits
    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign fits      = (trial >= {1'b0, div_reg});
    assign rem_step  = fits ? IN_TIME_W'(trial - {1'b0, div_reg}) : trial[IN_TIME_W-1:0];
    assign quo_step  = {quo_reg[NUM_W-2:0], fits};
    assign last_step = (step_reg == STEP_W'(NUM_W - 1));

    always_comb
    begin
        state_next  = state_reg;
        pop         = 1'b0;
        tempo.valid = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = zero_reg ? BK_OUT : BK_DIV;
            end
            BK_DIV:
            begin
                if (last_step)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                tempo.valid = 1'b1;
                if (tempo.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                beats_reg   <= job.total_beats_q8;
                div_reg     <= job.elapsed;
                db_time_reg <= job.downbeat_time;
                seq_reg     <= job.sequence_number;
                zero_reg    <= (job.elapsed == '0);
            end
            BK_MUL:
            begin
                num_reg  <= NUM_W'(beats_reg) * NUM_W'(USEC_PER_MINUTE);
                quo_reg  <= '0;
                rem_reg  <= '0;
                step_reg <= '0;
                if (zero_reg)
                begin
                    tempo_reg <= TEMPO_MAX;
                end
            end
            BK_DIV:
            begin
                num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                rem_reg  <= rem_step;
                quo_reg  <= quo_step;
                step_reg <= step_reg + STEP_W'(1);
                if (last_step)
                begin
                    // saturate the quotient to the tempo range
                    tempo_reg <= (quo_step > NUM_W'(TEMPO_MAX)) ? TEMPO_MAX
                                                                : quo_step[TEMPO_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign tempo.tempo_q8         = tempo_reg;
    assign tempo.downbeat_time_us = db_time_reg;
    assign tempo.sequence_number  = seq_reg;
    assign tempo.zero_elapsed     = zero_reg;

endmodule

`default_nettype wire
